/* rtl/lru_lookup_cache_with_retry_macros.svh */
// Assertion helpers shared by the cache RTL.
// Each use names its own label and takes the clock, the reset, a condition
// and a consequence.
`ifndef LRU_LOOKUP_CACHE_WITH_RETRY_MACROS_SVH
`define LRU_LOOKUP_CACHE_WITH_RETRY_MACROS_SVH

// Same-cycle implication.
`define LRULC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru cache check failed");

// Next-cycle implication.
`define LRULC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru cache check failed");

`endif

/* rtl/lrulc_pkg.sv */
// ----------------------------------------------------------------------------
// lrulc_pkg
// Request, result and entry types and fixed constants of the LRU lookup cache.
// ----------------------------------------------------------------------------
package lrulc_pkg;

  localparam logic OP_LOOKUP   = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  localparam logic [31:0] RETRY_RESET = 32'd60000;

  typedef logic [4:0] index_t;

  typedef struct packed {
    logic        opcode;
    logic [23:0] icao;
    logic [63:0] callsign;
    logic [31:0] now_ms;
    logic        route_found;
    logic        aircraft_found;
  } item_t;

  typedef struct packed {
    logic        valid_result;
    logic        hit;
    index_t      entry_index;
    logic        pending;
    logic        failed;
    logic        has_route;
    logic        has_aircraft;
    logic        issue_request;
    logic [63:0] request_callsign;
  } result_t;

  typedef struct packed {
    logic aircraft;
    logic route;
    logic failed;
    logic pending;
  } flags_t;

  typedef struct packed {
    logic [23:0] key;
    logic [63:0] name;
    logic [31:0] last_use;
    logic [31:0] last_try;
    flags_t      flags;
  } entry_t;

endpackage

/* rtl/lrulc_ram.sv */
// ----------------------------------------------------------------------------
// lrulc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrulc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/lru_lookup_cache_with_retry.sv */
// ----------------------------------------------------------------------------
// lru_lookup_cache_with_retry
// Fully associative LRU cache of fetch state keyed by a 24-bit identifier.
// ----------------------------------------------------------------------------
// Usage:
//   item_valid/item_stall/item carry one request: a lookup or a fetch
//   completion. result_valid/result_stall/result return exactly one result
//   per request, in order. cfg_valid/cfg_ready/cfg_data write the retry
//   interval in ms; cfg_ready is always high, write only while idle.
// Timing:
//   Each request scans all ENTRIES entries of the entry RAM, one read per
//   cycle, then passes through a drain state and an update state. The result
//   is registered in the update state, and the next request is taken only
//   once the sequencer is back in idle. A lookup with key zero skips the
//   scan and the drain and goes straight to the update state. The single RAM
//   read port sets the pace of the scan.
// Reset:
//   rst clears all valid bits at once and loads the retry interval with
//   60000 ms; no clearing pass is needed.
// Stall:
//   A valid result holds while result_stall is high. A new request is
//   still taken and scanned; its update waits until the result slot frees.
// ----------------------------------------------------------------------------
`include "lru_lookup_cache_with_retry_macros.svh"

module lru_lookup_cache_with_retry #(
  parameter int ENTRIES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  lrulc_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output lrulc_pkg::result_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam int ENTRY_W = $bits(lrulc_pkg::entry_t);

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    SCAN   = 4'b0010,
    DRAIN  = 4'b0100,
    UPDATE = 4'b1000
  } state_t;

  state_t state;

  // Request under work and the scan bookkeeping.
  lrulc_pkg::item_t  req;
  logic              req_null;
  logic [IDX_W-1:0]  scan_addr;
  logic              chk_vld;
  logic [IDX_W-1:0]  chk_addr;
  logic              hit_found;
  logic [IDX_W-1:0]  hit_idx;
  lrulc_pkg::entry_t hit_word;
  logic              pick_free;
  logic [IDX_W-1:0]  pick_idx;
  logic [31:0]       pick_lu;
  logic [ENTRIES-1:0] valid_bits;
  logic [31:0]       retry_after_ms;

  lrulc_pkg::entry_t rdata;
  lrulc_pkg::entry_t base_word;
  lrulc_pkg::entry_t new_word;
  lrulc_pkg::result_t result_next;
  logic [IDX_W-1:0]  upd_idx;
  logic [31:0]       elapsed;
  logic              issue;
  logic              chk_hit;
  logic              upd_go;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != IDLE);

  // Update may fire only when the result slot is free or being emptied.
  assign upd_go = (state == UPDATE) && !(result_valid && result_stall);

  // --------------------------------------------------------------------------
  // Entry store: key, name, timestamps and flags, one word per entry.
  // --------------------------------------------------------------------------
  lrulc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (upd_go && !req_null),
    .waddr (upd_idx),
    .wdata (new_word),
    .re    (state == SCAN),
    .raddr (scan_addr),
    .rdata (rdata)
  );

  // A returning word matches when its entry is live and the key agrees.
  assign chk_hit = valid_bits[chk_addr] && (rdata.key == req.icao);

  // --------------------------------------------------------------------------
  // Update: build the new entry word and the result from the scan outcome.
  // A claimed entry starts from all-zero contents but for its key.
  // --------------------------------------------------------------------------
  always_comb begin
    upd_idx   = hit_found ? hit_idx : pick_idx;
    base_word = '0;
    if (hit_found) begin
      base_word = hit_word;
    end else begin
      base_word.key = req.icao;
    end
    elapsed  = req.now_ms - base_word.last_try;
    new_word = base_word;
    new_word.last_use = req.now_ms;
    issue    = 1'b0;

    if (req.opcode == lrulc_pkg::OP_LOOKUP) begin
      if (!hit_found) begin
        new_word.name          = req.callsign;
        new_word.flags         = '0;
        new_word.flags.pending = 1'b1;
        new_word.last_try      = req.now_ms;
        issue                  = 1'b1;
      end else if (base_word.flags.failed && (elapsed > retry_after_ms)) begin
        new_word.flags.failed  = 1'b0;
        new_word.flags.pending = 1'b1;
        new_word.last_try      = req.now_ms;
        issue                  = 1'b1;
      end
    end else begin
      new_word.name           = req.callsign;
      new_word.flags.pending  = 1'b0;
      new_word.flags.route    = req.route_found;
      new_word.flags.aircraft = req.aircraft_found;
      new_word.flags.failed   = !req.route_found && !req.aircraft_found;
      new_word.last_try       = req.now_ms;
    end

    result_next = '0;
    if (!req_null) begin
      result_next.valid_result  = 1'b1;
      result_next.hit           = hit_found;
      result_next.entry_index   = lrulc_pkg::index_t'(upd_idx);
      result_next.pending       = new_word.flags.pending;
      result_next.failed        = new_word.flags.failed;
      result_next.has_route     = new_word.flags.route;
      result_next.has_aircraft  = new_word.flags.aircraft;
      result_next.issue_request = issue;
      if (req.opcode == lrulc_pkg::OP_LOOKUP) begin
        result_next.request_callsign = new_word.name;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control: sequencer, valid bits, scan flags, result handshake, register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      chk_vld        <= 1'b0;
      hit_found      <= 1'b0;
      pick_free      <= 1'b0;
      valid_bits     <= '0;
      result_valid   <= 1'b0;
      retry_after_ms <= lrulc_pkg::RETRY_RESET;
    end else begin
      if (cfg_valid) begin
        retry_after_ms <= cfg_data;
      end

      // Raise the result on update; drop it once the receiver takes it.
      if (upd_go) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      chk_vld <= (state == SCAN);

      // Fold each returning word into the hit and victim choice.
      if (chk_vld) begin
        if (chk_hit && !hit_found) begin
          hit_found <= 1'b1;
        end
        if (!pick_free && !valid_bits[chk_addr]) begin
          pick_free <= 1'b1;
        end
      end

      unique case (state)
        IDLE: begin
          if (item_valid) begin
            hit_found <= 1'b0;
            pick_free <= 1'b0;
            if ((item.opcode == lrulc_pkg::OP_LOOKUP) && (item.icao == '0)) begin
              state <= UPDATE;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (scan_addr == LAST_IDX) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= UPDATE;
        end
        UPDATE: begin
          if (upd_go) begin
            if (!req_null) begin
              valid_bits[upd_idx] <= 1'b1;
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload: request copy, scan address, captured hit word, victim tracking, result.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    chk_addr <= scan_addr;

    if (state == IDLE) begin
      req       <= item;
      req_null  <= (item.opcode == lrulc_pkg::OP_LOOKUP) && (item.icao == '0);
      scan_addr <= '0;
      pick_idx  <= '0;
      pick_lu   <= '0;
    end else if (state == SCAN) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end

    if (chk_vld) begin
      if (chk_hit && !hit_found) begin
        hit_idx  <= chk_addr;
        hit_word <= rdata;
      end
      // First free entry wins; else the oldest last use, lowest index on a tie.
      if (!pick_free) begin
        if (!valid_bits[chk_addr]) begin
          pick_idx <= chk_addr;
        end else if ((chk_addr == '0) || (rdata.last_use < pick_lu)) begin
          pick_idx <= chk_addr;
          pick_lu  <= rdata.last_use;
        end
      end
    end

    if (upd_go) begin
      result <= result_next;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `LRULC_ASSERT_NEXT(a_accept_starts_work, clk, rst, item_valid && !item_stall,
    (state == SCAN) || (state == UPDATE))
  `LRULC_ASSERT_NOW(a_result_from_update, clk, rst, $rose(result_valid),
    $past(state == UPDATE))
  `LRULC_ASSERT_NOW(a_issue_is_pending, clk, rst, result_valid && result.issue_request,
    result.pending && !result.failed)
  `LRULC_ASSERT_NOW(a_failed_knows_nothing, clk, rst, result_valid && result.failed,
    !result.has_route && !result.has_aircraft && !result.pending)
  `LRULC_ASSERT_NOW(a_scan_in_range, clk, rst, chk_vld, chk_addr <= LAST_IDX)

endmodule

/* tb/lru_lookup_cache_with_retry_tb.sv */
// ----------------------------------------------------------------------------
// LRU lookup cache testbench
// Drives lookups and fetch completions into the cache under random sender
// gaps and result stalls, predicts every result from a shadow copy of the
// entries, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module lru_lookup_cache_with_retry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES    = 24;
  localparam int CYCLE_CAP  = 1000000;
  localparam int PHASE_REQS = 215;

  // Shadow of the cache contents plus the queue of results still owed.
  class cache_model;
    bit                  live[ENTRIES];
    bit [23:0]           key[ENTRIES];
    bit [63:0]           name[ENTRIES];
    bit [31:0]           last_use[ENTRIES];
    bit [31:0]           last_try[ENTRIES];
    lrulc_pkg::flags_t   flags[ENTRIES];
    bit [31:0]           retry_ms;
    lrulc_pkg::result_t  due[$];
    int                  mismatches;

    function new();
      retry_ms   = lrulc_pkg::RETRY_RESET;
      mismatches = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        live[i]     = 1'b0;
        key[i]      = '0;
        name[i]     = '0;
        last_use[i] = '0;
        last_try[i] = '0;
        flags[i]    = '0;
      end
    endfunction

    // Work out the result of one accepted request and advance the shadow.
    function void note_request(lrulc_pkg::item_t it);
      lrulc_pkg::result_t r;
      int                 slot;
      bit                 found;
      bit                 issue;
      bit [31:0]          elapsed;
      lrulc_pkg::flags_t  f;
      r     = '0;
      slot  = -1;
      issue = 1'b0;
      if (it.opcode == lrulc_pkg::OP_LOOKUP && it.icao == 24'd0) begin
        due.push_back(r);
        return;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && live[i] && key[i] == it.icao) slot = i;
      end
      found = (slot >= 0);
      if (!found) begin
        // first free entry, else least recently used, lowest index on a tie
        slot = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!live[i]) begin
            slot = i;
            break;
          end
          if (last_use[i] < last_use[slot]) slot = i;
        end
        live[slot]     = 1'b1;
        key[slot]      = it.icao;
        name[slot]     = '0;
        last_use[slot] = '0;
        last_try[slot] = '0;
        flags[slot]    = '0;
      end
      if (it.opcode == lrulc_pkg::OP_LOOKUP) begin
        elapsed = it.now_ms - last_try[slot];
        if (!found) begin
          name[slot]          = it.callsign;
          flags[slot]         = '0;
          flags[slot].pending = 1'b1;
          last_try[slot]      = it.now_ms;
          issue               = 1'b1;
        end else if (flags[slot].failed && elapsed > retry_ms) begin
          flags[slot].failed  = 1'b0;
          flags[slot].pending = 1'b1;
          last_try[slot]      = it.now_ms;
          issue               = 1'b1;
        end
        last_use[slot]     = it.now_ms;
        r.request_callsign = name[slot];
      end else begin
        f              = '0;
        f.route        = it.route_found;
        f.aircraft     = it.aircraft_found;
        f.failed       = !it.route_found && !it.aircraft_found;
        name[slot]     = it.callsign;
        flags[slot]    = f;
        last_use[slot] = it.now_ms;
        last_try[slot] = it.now_ms;
      end
      r.valid_result  = 1'b1;
      r.hit           = found;
      r.entry_index   = slot[4:0];
      r.pending       = flags[slot].pending;
      r.failed        = flags[slot].failed;
      r.has_route     = flags[slot].route;
      r.has_aircraft  = flags[slot].aircraft;
      r.issue_request = issue;
      due.push_back(r);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest owed one.
    function void check_result(lrulc_pkg::result_t got);
      lrulc_pkg::result_t want;
      if (due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none owed: expected nothing, actual %h", $time, got);
        return;
      end
      want = due.pop_front();
      report("valid_result", want.valid_result, got.valid_result);
      report("hit", want.hit, got.hit);
      report("entry_index", want.entry_index, got.entry_index);
      report("pending", want.pending, got.pending);
      report("failed", want.failed, got.failed);
      report("has_route", want.has_route, got.has_route);
      report("has_aircraft", want.has_aircraft, got.has_aircraft);
      report("issue_request", want.issue_request, got.issue_request);
      report("request_callsign", want.request_callsign, got.request_callsign);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  lrulc_pkg::item_t   item;
  logic               result_valid;
  logic               result_stall;
  lrulc_pkg::result_t result;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;

  cache_model  shadow;
  int          cycle_count = 0;
  int          stall_run = 0;
  bit          steady = 1'b0;   // set during the phase with no sender gaps and no new result stalls
  bit [31:0]   clock_ms = '0;

  lru_lookup_cache_with_retry #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: the slowest legal run is far below this cap.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: stall at random, sometimes in long bursts; no new stall starts while steady.
  // Exactly one assignment per falling edge keeps the stall free of races.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      result_stall <= 1'b1;
    end else if (!steady && $urandom_range(0, 99) < 1) begin
      stall_run = $urandom_range(1, 20);
      result_stall <= 1'b1;
    end else begin
      result_stall <= !steady && ($urandom_range(0, 99) < 12);
    end
  end

  // Sample results at the rising edge; a result moves when valid and not stalled.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) shadow.check_result(result);
  end

  function automatic lrulc_pkg::item_t make_item(logic op, logic [23:0] k,
                                                 logic [63:0] cs, logic [31:0] t,
                                                 logic rk, logic ak);
    lrulc_pkg::item_t it;
    it.opcode         = op;
    it.icao           = k;
    it.callsign       = cs;
    it.now_ms         = t;
    it.route_found    = rk;
    it.aircraft_found = ak;
    return it;
  endfunction

  // Present one request, hold it while stalled, and log it once it is taken.
  // Valid stays high across back-to-back requests; gaps drop it for whole cycles.
  task automatic send_request(input lrulc_pkg::item_t it);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(0, 99) < 21) gap++;
    if (!steady && $urandom_range(0, 99) < 3) gap += $urandom_range(1, 40);
    @(negedge clk);
    while (gap > 0) begin
      item_valid <= 1'b0;
      gap--;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    shadow.note_request(it);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (shadow.due.size() != 0) @(negedge clk);
  endtask

  // Write the retry interval; only called with the cache idle.
  task automatic write_retry(input logic [31:0] ms);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.retry_ms = ms;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Directed walk through the corner cases, under the reset retry interval.
  task automatic run_directed();
    // zero key lookup: no effect, all-zero result
    send_request(make_item(lrulc_pkg::OP_LOOKUP, 24'h0, '1, '1, 1'b1, 1'b1));
    // miss at the top key, then a hit that must keep the stored name
    send_request(make_item(lrulc_pkg::OP_LOOKUP, 24'hFFFFFF, '1, 32'd100, 1'b0, 1'b0));
    send_request(make_item(lrulc_pkg::OP_LOOKUP, 24'hFFFFFF, 64'h0123456789ABCDEF,
                           32'd200, 1'b0, 1'b0));
    send_request(make_item(lrulc_pkg::OP_COMPLETE, 24'hFFFFFF, 64'h5555AAAA5555AAAA,
                           32'd250, 1'b1, 1'b1));
    // completion for an absent key claims an entry and fails it
    send_request(make_item(lrulc_pkg::OP_COMPLETE, 24'h000001, 64'hAAAA5555AAAA5555,
                           32'd300, 1'b0, 1'b0));
    // hits on the failed entry: inside, exactly at, then past the interval
    send_request(make_item(lrulc_pkg::OP_LOOKUP, 24'h000001, '0, 32'd400, 1'b0, 1'b0));
    send_request(make_item(lrulc_pkg::OP_LOOKUP, 24'h000001, '0, 32'd60300, 1'b0, 1'b0));
    send_request(make_item(lrulc_pkg::OP_LOOKUP, 24'h000001, '0, 32'd60301, 1'b0, 1'b0));
    send_request(make_item(lrulc_pkg::OP_COMPLETE, 24'h000001, 64'h1, 32'd60400,
                           1'b1, 1'b0));
    send_request(make_item(lrulc_pkg::OP_COMPLETE, 24'h000002, 64'h2, 32'd60500,
                           1'b0, 1'b1));
    // completion with key zero claims an entry; a zero lookup still ignores it
    send_request(make_item(lrulc_pkg::OP_COMPLETE, 24'h0, 64'h3, 32'd60600, 1'b0, 1'b0));
    send_request(make_item(lrulc_pkg::OP_LOOKUP, 24'h0, 64'h4, 32'd60700, 1'b0, 1'b0));
    // fill the cache and push past it to force evictions; the first four fills share a time
    for (int i = 0; i < 24; i++) begin
      send_request(make_item(lrulc_pkg::OP_LOOKUP, 24'h800000 | 24'(i),
                             {$urandom, $urandom},
                             (i < 4) ? 32'd70000 : 32'd70000 + 32'(i), 1'b0, 1'b0));
    end
  endtask

  // Random phase: a small key pool keeps hits, completions and evictions mixed.
  task automatic run_random(input int count);
    bit [23:0]        pool[$];
    bit [23:0]        k;
    lrulc_pkg::item_t it;
    int               roll;
    int               adv;
    int               pool_size;
    logic             rk;
    logic             ak;
    pool_size = $urandom_range(8, 48);
    for (int i = 0; i < pool_size; i++) begin
      k = 24'($urandom_range(1, 24'hFFFFFF));
      pool.push_back(k);
    end
    for (int n = 0; n < count; n++) begin
      adv = $urandom_range(0, 99);
      if (adv < 20) clock_ms = clock_ms;
      else if (adv < 70) clock_ms += $urandom_range(1, 2000);
      else if (adv < 97) clock_ms += $urandom_range(0, 100000);
      else clock_ms = $urandom;
      k    = pool[$urandom_range(0, pool_size - 1)];
      rk   = 1'($urandom_range(0, 1));
      ak   = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 40) begin
        rk = 1'b0;
        ak = 1'b0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        it = make_item(lrulc_pkg::OP_LOOKUP, 24'h0, {$urandom, $urandom}, clock_ms,
                       rk, ak);
      end else if (roll < 10) begin
        k  = 24'($urandom_range(1, 24'hFFFFFF));
        it = make_item(lrulc_pkg::OP_LOOKUP, k, {$urandom, $urandom}, clock_ms, rk, ak);
      end else if (roll < 14) begin
        k  = 24'($urandom);
        it = make_item(lrulc_pkg::OP_COMPLETE, k, {$urandom, $urandom}, clock_ms, rk, ak);
      end else if (roll < 40) begin
        it = make_item(lrulc_pkg::OP_COMPLETE, k, {$urandom, $urandom}, clock_ms, rk, ak);
      end else begin
        it = make_item(lrulc_pkg::OP_LOOKUP, k, {$urandom, $urandom}, clock_ms, rk, ak);
      end
      send_request(it);
    end
  endtask

  initial begin
    logic [31:0] retry_plan[6];
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_stall = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    shadow       = new();
    // zero, max and a few in between; a random one keeps the bits moving
    retry_plan[0] = 32'd1000;
    retry_plan[1] = 32'd0;
    retry_plan[2] = 32'hFFFFFFFF;
    retry_plan[3] = $urandom;
    retry_plan[4] = $urandom_range(1, 5000);
    retry_plan[5] = lrulc_pkg::RETRY_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    clock_ms = 32'd80000;
    for (int p = 0; p < 6; p++) begin
      drain();
      write_retry(retry_plan[p]);
      steady = (p == 2);
      run_random(PHASE_REQS);
    end
    steady = 1'b0;
    drain();
    // let any stray result show up before the verdict
    repeat (40) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lrulc_pkg.sv
rtl/lrulc_ram.sv
rtl/lru_lookup_cache_with_retry.sv
tb/lru_lookup_cache_with_retry_tb.sv
